// ===== rtl/rm_pkg.sv =====
`default_nettype none

package rm_pkg;

	// Store size and the derived positions in the cell row.
	localparam int CAPACITY = 1024;
	localparam int MID      = CAPACITY / 2;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed field widths.
	localparam int SAMPLE_W = 32;
	localparam int MEDIAN_W = 33;
	localparam int COUNT_W  = 11;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [MEDIAN_W-1:0] median_t;
	typedef logic [CNT_W-1:0]           count_t;

	// Per-cycle command broadcast to every cell of the row.
	typedef struct packed {
		logic ins;         // an item is being inserted this cycle
		logic shift_down;  // smaller-or-equal samples move toward cell 0
	} cell_ctl_t;

	// Control handed from the insertion stage to the median output stage.
	typedef struct packed {
		logic   fire;   // an item was taken in the previous cycle
		logic   full;   // that item was dropped because the store was full
		logic   odd;    // the count now held is odd
		count_t count;  // the count now held
	} med_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/running_median.sv =====
`default_nettype none

// Running median of a signed 32-bit sample stream.
//
// Input: raise start with a sample while busy is low and the sample is taken
// at that clock edge. busy never rises, so a new sample can be given in every
// cycle: one item per clock cycle, sustained.
// Output: once a sample clears the stage and result registers, done is high
// for exactly one cycle with median_twice (twice the median of all samples
// held, one fractional bit), sample_count (samples held after this item) and
// store_full (the sample was dropped because the store already held CAPACITY
// samples). The receiver cannot stall; a result is gone after its cycle.
// The store is a row of CAPACITY cells kept in sorted order around a fixed
// middle cell. Every cell compares the new sample in the same cycle and
// takes its neighbor's value, the sample or its own value, so insertion
// is a single register update. The sorted run grows upward on an even count
// and downward on an odd one, keeping the median in the two middle cells; a
// registered add of the two (the upper one doubled if odd) gives the result.
// Reset empties every cell and clears the count; no clearing pass is needed.
module running_median import rm_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire sample_t sample,
	output logic         done,
	output median_t      median_twice,
	output logic [COUNT_W-1:0] sample_count,
	output logic         store_full
);

	logic      accept;
	logic      is_full;
	count_t    count_q;
	logic      fire_s1;
	logic      full_s1;
	cell_ctl_t cell_ctl;
	med_ctl_t  med_ctl;

	// The row is padded by one dummy position at each end so that every
	// cell sees a left and a right neighbor. The pads never shift inward.
	sample_t             chain_data [0:CAPACITY+1];
	logic [CAPACITY+1:0] chain_valid;
	logic [CAPACITY+1:0] chain_flag;

	// The block can take an item in every cycle.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Once the store is full further samples are dropped and flagged.
	assign is_full = (count_q == CNT_W'(CAPACITY));

	// An even count grows the sorted run by one toward the top end, an odd
	// count grows it toward cell 0, so the middle stays fixed.
	assign cell_ctl.ins        = accept & ~is_full;
	assign cell_ctl.shift_down = count_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fire_s1 <= 1'b0;
			full_s1 <= 1'b0;
		end else begin
			if (cell_ctl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end
			fire_s1 <= accept;
			full_s1 <= is_full;
		end
	end

	assign chain_data[0]            = '0;
	assign chain_valid[0]           = 1'b0;
	assign chain_flag[0]            = 1'b0;
	assign chain_data[CAPACITY+1]   = '0;
	assign chain_valid[CAPACITY+1]  = 1'b0;
	assign chain_flag[CAPACITY+1]   = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl),
			.sample     (sample),
			.upper      ((i >= MID) ? 1'b1 : 1'b0),
			.prev_data  (chain_data[i]),
			.prev_flag  (chain_flag[i]),
			.prev_valid (chain_valid[i]),
			.next_data  (chain_data[i+2]),
			.next_flag  (chain_flag[i+2]),
			.next_valid (chain_valid[i+2]),
			.data       (chain_data[i+1]),
			.valid      (chain_valid[i+1]),
			.flag       (chain_flag[i+1])
		);
	end

	// In the cycle after an insertion the count and cells already reflect
	// it; the median stage samples them then.
	assign med_ctl.fire  = fire_s1;
	assign med_ctl.full  = full_s1;
	assign med_ctl.odd   = count_q[0];
	assign med_ctl.count = count_q;

	rm_median u_median (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (med_ctl),
		.lo_mid       (chain_data[MID]),
		.hi_mid       (chain_data[MID+1]),
		.done         (done),
		.median_twice (median_twice),
		.sample_count (sample_count),
		.store_full   (store_full)
	);

	// Every accepted item yields its result strobe after the stage and result registers.
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("result strobe missing two cycles after an accepted item");

	// Once any sample is held, the upper middle cell holds a valid sample.
	a_mid_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> chain_valid[MID+1])
		else $error("middle cell empty while the store holds samples");

	// The count moves only on an insertion (the design itself stops it at the capacity).
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!cell_ctl.ins |=> $stable(count_q))
		else $error("sample count changed without an insertion");

	// A dropped sample is reported with a full count.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && store_full) |-> (sample_count == COUNT_W'(CAPACITY)))
		else $error("store_full reported with a count below capacity");

endmodule

`default_nettype wire

// ===== rtl/rm_cell.sv =====
`default_nettype none

module rm_cell import rm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire sample_t   sample,
	input  wire logic      upper,
	input  wire sample_t   prev_data,
	input  wire logic      prev_flag,
	input  wire logic      prev_valid,
	input  wire sample_t   next_data,
	input  wire logic      next_flag,
	input  wire logic      next_valid,
	output sample_t        data,
	output logic           valid,
	output logic           flag
);

	sample_t data_q;
	logic    valid_q;

	// When shifting down the flag marks cells holding a value no greater than
	// the sample; when shifting up it marks cells holding a greater value.
	// An empty cell counts as minus infinity below the middle and as plus
	// infinity from the middle up.
	always_comb begin
		if (valid_q) begin
			flag = ctl.shift_down ? (data_q <= sample) : (data_q > sample);
		end else begin
			flag = ctl.shift_down ? ~upper : upper;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins) begin
			if (ctl.shift_down) begin
				if (next_flag) begin
					valid_q <= next_valid;
				end else if (flag) begin
					valid_q <= 1'b1;
				end
			end else begin
				if (prev_flag) begin
					valid_q <= prev_valid;
				end else if (flag) begin
					valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (ctl.shift_down) begin
				if (next_flag) begin
					data_q <= next_data;
				end else if (flag) begin
					data_q <= sample;
				end
			end else begin
				if (prev_flag) begin
					data_q <= prev_data;
				end else if (flag) begin
					data_q <= sample;
				end
			end
		end
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule

`default_nettype wire

// ===== rtl/rm_median.sv =====
`default_nettype none

module rm_median import rm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire med_ctl_t ctl,
	input  wire sample_t  lo_mid,
	input  wire sample_t  hi_mid,
	output logic          done,
	output median_t       median_twice,
	output logic [COUNT_W-1:0] sample_count,
	output logic          store_full
);

	logic               done_q;
	median_t            median_q;
	logic [COUNT_W-1:0] count_q;
	logic               full_q;
	median_t            median_d;

	// The middle cells sit at fixed places, so the median is one add or, if odd, a doubling.
	always_comb begin
		if (ctl.odd) begin
			median_d = {hi_mid, 1'b0};
		end else begin
			median_d = {lo_mid[SAMPLE_W-1], lo_mid} + {hi_mid[SAMPLE_W-1], hi_mid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			median_q <= median_d;
			count_q  <= COUNT_W'(ctl.count);
			full_q   <= ctl.full;
		end
	end

	assign done         = done_q;
	assign median_twice = median_q;
	assign sample_count = count_q;
	assign store_full   = full_q;

endmodule

`default_nettype wire
